// ----- sv/assert_macros.svh -----
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that must hold at every edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- sv/spvm_pkg.sv -----
// Package of types and constants for the sample playback voice mixer.
package spvm_pkg;

    // Default configuration of the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 16384;
    localparam int VOICE_SLOTS_DEF = 16;

    // Fixed field widths.
    localparam int ACTION_W  = 2;
    localparam int SOUND_W   = 2;
    localparam int ADDR_W    = 14;
    localparam int SAMPLE_W  = 16;
    localparam int MIX_W     = 21;
    localparam int VOICES_W  = 5;
    localparam int LEN_W     = 15;
    localparam int CFG_IDX_W = 2;

    // Clipping limits of the Q5.15 mix.
    localparam int MIX_MAX = 1048575;
    localparam int MIX_MIN = -1048576;

    // Length registers after reset.
    localparam logic [LEN_W-1:0] BEEP_LENGTH_RST = 15'd4800;
    localparam logic [LEN_W-1:0] PEW_LENGTH_RST  = 15'd2880;
    localparam logic [LEN_W-1:0] BOOM_LENGTH_RST = 15'd12000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BEEP_LENGTH = 2'd0,
        REG_PEW_LENGTH  = 2'd1,
        REG_BOOM_LENGTH = 2'd2,
        REG_UNUSED      = 2'd3
    } spvm_reg_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_LOAD    = 2'd2,
        ACT_NOP     = 2'd3
    } spvm_action_t;

    typedef enum logic [SOUND_W-1:0] {
        SND_BEEP    = 2'd0,
        SND_PEW     = 2'd1,
        SND_BOOM    = 2'd2,
        SND_INVALID = 2'd3
    } spvm_sound_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TRIG,
        ST_TICK,
        ST_DRAIN,
        ST_RESULT
    } spvm_state_t;

endpackage

// ----- sv/spvm_wave_ram.sv -----
// Single-port wave table memory with a registered read.
module spvm_wave_ram #(
    parameter int DEPTH  = 3 * spvm_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             addr,
    input  logic [spvm_pkg::SAMPLE_W-1:0] wr_data,
    output logic [spvm_pkg::SAMPLE_W-1:0] rd_data
);

    logic [spvm_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

// ----- sv/sample_playback_voice_mixer_unit.sv -----
// Top level of the sample playback voice mixer: sequencer, voice slots and mix.
//
// The mixer plays up to VOICE_SLOTS overlapping instances of three one-shot sounds
// (beep, pew and boom) held in a wave table of 3 * TABLE_DEPTH Q1.15 words. Each
// transaction on the item channel is one action: a load writes one table word, a
// trigger starts a voice of a sound in the lowest-numbered free slot (or reports
// trigger_dropped when every slot is busy), a tick sums the current word of every
// active voice, advances each voice and frees those that reach their sound's
// length, and the fourth action code does nothing. Every item gives exactly one
// result transaction, carrying the clipped Q5.15 mix and its clip flag on a tick,
// and the number of playing voices in all cases. A single voice-slot unit (one
// length compare, one position increment and one table address adder) is walked
// over the slots one per cycle, and the wave table has one port, so a tick holds
// the block until every slot has been visited and the last read added, a trigger
// until a free slot is found or the last slot is passed, a load for its table
// write, and the idle action or a trigger of the fourth sound code go straight to
// the result. No new item is accepted before the last result is registered.
// Results leave through an output register, so a result may wait for its consumer
// while the next item is already accepted. The wave table is not cleared: reading
// a word that was never loaded gives an unspecified value. Length registers may
// be written only while the block is idle.

`include "assert_macros.svh"

module sample_playback_voice_mixer_unit #(
    parameter int TABLE_DEPTH = spvm_pkg::TABLE_DEPTH_DEF,
    parameter int VOICE_SLOTS = spvm_pkg::VOICE_SLOTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_write,
    input  logic [spvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [spvm_pkg::LEN_W-1:0]            cfg_data,
    // Item channel.
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic [spvm_pkg::ACTION_W-1:0]         action,
    input  logic [spvm_pkg::SOUND_W-1:0]          sound,
    input  logic [spvm_pkg::ADDR_W-1:0]           table_addr,
    input  logic signed [spvm_pkg::SAMPLE_W-1:0]  table_value,
    // Result channel.
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [spvm_pkg::MIX_W-1:0]     mix_sample,
    output logic                                  mix_saturated,
    output logic                                  trigger_dropped,
    output logic [spvm_pkg::VOICES_W-1:0]         active_voices
);

    // Derived sizes.
    localparam int POS_W     = $clog2(TABLE_DEPTH);
    localparam int TLEN_W    = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W     = (TLEN_W > spvm_pkg::LEN_W) ? TLEN_W : spvm_pkg::LEN_W;
    localparam int MEM_DEPTH = 3 * TABLE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int SLOT_W    = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CNT_W     = $clog2(VOICE_SLOTS + 1);
    localparam int ACC_W     = spvm_pkg::SAMPLE_W + $clog2(VOICE_SLOTS);
    localparam int SAT_W     = (ACC_W > spvm_pkg::MIX_W) ? ACC_W : spvm_pkg::MIX_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(VOICE_SLOTS - 1);
    localparam logic [CMP_W-1:0]  DEPTH_CMP  = CMP_W'(TABLE_DEPTH);
    localparam logic [MEM_AW-1:0] PEW_BASE   = MEM_AW'(TABLE_DEPTH);
    localparam logic [MEM_AW-1:0] BOOM_BASE  = MEM_AW'(2 * TABLE_DEPTH);
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(spvm_pkg::MIX_MAX);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(spvm_pkg::MIX_MIN);

    // Sequencer state.
    spvm_pkg::spvm_state_t state_reg, state_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;

    // The item being worked on.
    spvm_pkg::spvm_action_t        action_reg;
    spvm_pkg::spvm_sound_t         sound_reg;
    logic [spvm_pkg::ADDR_W-1:0]   addr_reg;
    logic [spvm_pkg::SAMPLE_W-1:0] value_reg;

    // Length registers, one per sound.
    logic [spvm_pkg::LEN_W-1:0] beep_len_reg, pew_len_reg, boom_len_reg;

    // Voice slots.
    logic [VOICE_SLOTS-1:0]          active_reg, active_next;
    logic [POS_W-1:0]                pos_reg    [VOICE_SLOTS];
    logic [POS_W-1:0]                pos_next   [VOICE_SLOTS];
    spvm_pkg::spvm_sound_t           vsound_reg [VOICE_SLOTS];
    spvm_pkg::spvm_sound_t           vsound_next[VOICE_SLOTS];
    logic [CNT_W-1:0]                count_reg, count_next;

    // Mix accumulator and pending table read.
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    add_pend_reg, add_pend_next;
    logic                    dropped_reg, dropped_next;

    // Result register.
    logic                                 result_valid_reg, result_valid_next;
    logic signed [spvm_pkg::MIX_W-1:0]    mix_reg, mix_next;
    logic                                 sat_reg, sat_next;
    logic                                 drop_out_reg, drop_out_next;
    logic [spvm_pkg::VOICES_W-1:0]        voices_reg, voices_next;

    // Voice-slot unit signals.
    logic                          cur_active;
    spvm_pkg::spvm_sound_t         cur_sound;
    logic [POS_W-1:0]              cur_pos;
    logic [spvm_pkg::LEN_W-1:0]    cur_len;
    logic [CMP_W-1:0]              len_ext, eff_len, pos_ext, pos_inc;
    logic                          in_range, voice_done;
    spvm_pkg::spvm_sound_t         base_sound;
    logic [MEM_AW-1:0]             base_addr, offset_addr, mem_addr;
    logic                          load_ok;

    // Table memory port.
    logic                          mem_wr_en, mem_rd_en;
    logic [spvm_pkg::SAMPLE_W-1:0] mem_rd_data;
    logic signed [ACC_W-1:0]       word_ext;

    // Saturation.
    logic signed [SAT_W-1:0]       acc_wide;
    logic signed [spvm_pkg::MIX_W-1:0] mix_clip;
    logic                          clip_flag;

    spvm_wave_ram #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (MEM_AW)
    ) u_wave_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (value_reg),
        .rd_data (mem_rd_data)
    );

    // The slot under the counter. A stored sound code of three cannot arise, but it
    // is folded onto the beep so that the table address stays in range.
    always_comb
    begin
        cur_active = active_reg[slot_reg];
        cur_pos    = pos_reg[slot_reg];
        if (vsound_reg[slot_reg] == spvm_pkg::SND_INVALID)
        begin
            cur_sound = spvm_pkg::SND_BEEP;
        end
        else
        begin
            cur_sound = vsound_reg[slot_reg];
        end
    end

    // Length of the slot's sound, limited to the table depth.
    always_comb
    begin
        case (cur_sound)
            spvm_pkg::SND_PEW:  cur_len = pew_len_reg;
            spvm_pkg::SND_BOOM: cur_len = boom_len_reg;
            default:            cur_len = beep_len_reg;
        endcase
        len_ext    = CMP_W'(cur_len);
        eff_len    = (len_ext > DEPTH_CMP) ? DEPTH_CMP : len_ext;
        pos_ext    = CMP_W'(cur_pos);
        pos_inc    = pos_ext + CMP_W'(1);
        in_range   = (pos_ext < eff_len);
        voice_done = !in_range || (pos_inc >= eff_len);
    end

    // One address adder serves both the tick reads and the load writes.
    always_comb
    begin
        if (state_reg == spvm_pkg::ST_TICK)
        begin
            base_sound  = cur_sound;
            offset_addr = MEM_AW'(cur_pos);
        end
        else
        begin
            base_sound  = sound_reg;
            offset_addr = MEM_AW'(addr_reg);
        end
        case (base_sound)
            spvm_pkg::SND_PEW:  base_addr = PEW_BASE;
            spvm_pkg::SND_BOOM: base_addr = BOOM_BASE;
            default:            base_addr = '0;
        endcase
        mem_addr = base_addr + offset_addr;
    end

    assign load_ok  = (sound_reg != spvm_pkg::SND_INVALID)
                      && (CMP_W'(addr_reg) < DEPTH_CMP);
    assign word_ext = ACC_W'($signed(mem_rd_data));

    // Clip the finished sum to the Q5.15 range.
    always_comb
    begin
        acc_wide = SAT_W'(acc_reg);
        if (acc_wide > SAT_MAX)
        begin
            mix_clip  = spvm_pkg::MIX_W'(SAT_MAX);
            clip_flag = 1'b1;
        end
        else if (acc_wide < SAT_MIN)
        begin
            mix_clip  = spvm_pkg::MIX_W'(SAT_MIN);
            clip_flag = 1'b1;
        end
        else
        begin
            mix_clip  = spvm_pkg::MIX_W'(acc_wide);
            clip_flag = 1'b0;
        end
    end

    assign item_ready = (state_reg == spvm_pkg::ST_IDLE);

    // Sequencer: next state and all register updates.
    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        active_next       = active_reg;
        pos_next          = pos_reg;
        vsound_next       = vsound_reg;
        count_next        = count_reg;
        acc_next          = acc_reg;
        add_pend_next     = add_pend_reg;
        dropped_next      = dropped_reg;
        result_valid_next = result_valid_reg && !result_ready;
        mix_next          = mix_reg;
        sat_next          = sat_reg;
        drop_out_next     = drop_out_reg;
        voices_next       = voices_reg;
        mem_wr_en         = 1'b0;
        mem_rd_en         = 1'b0;

        case (state_reg)
            spvm_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    slot_next     = '0;
                    acc_next      = '0;
                    add_pend_next = 1'b0;
                    dropped_next  = 1'b0;
                    case (spvm_pkg::spvm_action_t'(action))
                        spvm_pkg::ACT_TICK:
                        begin
                            state_next = spvm_pkg::ST_TICK;
                        end
                        spvm_pkg::ACT_TRIGGER:
                        begin
                            if (spvm_pkg::spvm_sound_t'(sound) != spvm_pkg::SND_INVALID)
                            begin
                                state_next = spvm_pkg::ST_TRIG;
                            end
                            else
                            begin
                                state_next = spvm_pkg::ST_RESULT;
                            end
                        end
                        spvm_pkg::ACT_LOAD:
                        begin
                            state_next = spvm_pkg::ST_LOAD;
                        end
                        default:
                        begin
                            state_next = spvm_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            spvm_pkg::ST_LOAD:
            begin
                mem_wr_en  = load_ok;
                state_next = spvm_pkg::ST_RESULT;
            end

            spvm_pkg::ST_TRIG:
            begin
                if (!cur_active)
                begin
                    active_next[slot_reg] = 1'b1;
                    pos_next[slot_reg]    = '0;
                    vsound_next[slot_reg] = sound_reg;
                    count_next            = count_reg + CNT_W'(1);
                    state_next            = spvm_pkg::ST_RESULT;
                end
                else if (slot_reg == LAST_SLOT)
                begin
                    dropped_next = 1'b1;
                    state_next   = spvm_pkg::ST_RESULT;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end

            spvm_pkg::ST_TICK:
            begin
                if (add_pend_reg)
                begin
                    acc_next = acc_reg + word_ext;
                end
                add_pend_next = cur_active && in_range;
                mem_rd_en     = cur_active && in_range;
                if (cur_active)
                begin
                    if (voice_done)
                    begin
                        active_next[slot_reg] = 1'b0;
                        pos_next[slot_reg]    = '0;
                        count_next            = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        pos_next[slot_reg] = POS_W'(pos_inc);
                    end
                end
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = spvm_pkg::ST_DRAIN;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end

            spvm_pkg::ST_DRAIN:
            begin
                if (add_pend_reg)
                begin
                    acc_next = acc_reg + word_ext;
                end
                add_pend_next = 1'b0;
                state_next    = spvm_pkg::ST_RESULT;
            end

            spvm_pkg::ST_RESULT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    if (action_reg == spvm_pkg::ACT_TICK)
                    begin
                        mix_next = mix_clip;
                        sat_next = clip_flag;
                    end
                    else
                    begin
                        mix_next = '0;
                        sat_next = 1'b0;
                    end
                    drop_out_next = dropped_reg;
                    voices_next   = spvm_pkg::VOICES_W'(count_reg);
                    state_next    = spvm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = spvm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= spvm_pkg::ST_IDLE;
            slot_reg         <= '0;
            active_reg       <= '0;
            count_reg        <= '0;
            add_pend_reg     <= 1'b0;
            dropped_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            active_reg       <= active_next;
            count_reg        <= count_next;
            add_pend_reg     <= add_pend_next;
            dropped_reg      <= dropped_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Length registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_len_reg <= spvm_pkg::BEEP_LENGTH_RST;
            pew_len_reg  <= spvm_pkg::PEW_LENGTH_RST;
            boom_len_reg <= spvm_pkg::BOOM_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (spvm_pkg::spvm_reg_t'(cfg_index))
                spvm_pkg::REG_BEEP_LENGTH: beep_len_reg <= cfg_data;
                spvm_pkg::REG_PEW_LENGTH:  pew_len_reg  <= cfg_data;
                spvm_pkg::REG_BOOM_LENGTH: boom_len_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        vsound_reg   <= vsound_next;
        acc_reg      <= acc_next;
        mix_reg      <= mix_next;
        sat_reg      <= sat_next;
        drop_out_reg <= drop_out_next;
        voices_reg   <= voices_next;
        if (item_valid && item_ready)
        begin
            action_reg <= spvm_pkg::spvm_action_t'(action);
            sound_reg  <= spvm_pkg::spvm_sound_t'(sound);
            addr_reg   <= table_addr;
            value_reg  <= table_value;
        end
    end

    assign result_valid    = result_valid_reg;
    assign mix_sample      = mix_reg;
    assign mix_saturated   = sat_reg;
    assign trigger_dropped = drop_out_reg;
    assign active_voices   = voices_reg;

    // The running voice count always matches the set of active slots.
    `ASSERT_CLK(a_count_matches, (count_reg == CNT_W'($countones(active_reg))), "voice count out of step with active slots")

    // A result is only raised from the result state of the sequencer.
    `ASSERT_CLK(a_result_source, $rose(result_valid_reg) |-> $past(state_reg == spvm_pkg::ST_RESULT), "result raised outside the result state")

    // The drain cycle always hands over to the result state.
    `ASSERT_CLK(a_drain_to_result, (state_reg == spvm_pkg::ST_DRAIN) |=> (state_reg == spvm_pkg::ST_RESULT), "drain not followed by result")

endmodule

// ----- test/sample_playback_voice_mixer_unit_tb.sv -----
// Self-checking testbench for the sample playback voice mixer, with its own prediction.
`timescale 1ns / 1ps

module sample_playback_voice_mixer_unit_tb;

    // The block is built with its default sizes, so the predictor uses the same.
    localparam int TABLE_DEPTH = spvm_pkg::TABLE_DEPTH_DEF;
    localparam int VOICE_SLOTS = spvm_pkg::VOICE_SLOTS_DEF;
    localparam int TABLE_WORDS = 3 * TABLE_DEPTH;

    // Field widths used throughout.
    localparam int ADDR_W   = spvm_pkg::ADDR_W;
    localparam int SAMPLE_W = spvm_pkg::SAMPLE_W;
    localparam int LEN_W    = spvm_pkg::LEN_W;
    localparam int MIX_W    = spvm_pkg::MIX_W;
    localparam int VOICES_W = spvm_pkg::VOICES_W;

    // Allowed to pass once the last result is in before a register write, long enough
    // for a tick to finish.
    localparam int SETTLE_CYCLES   = 2 * VOICE_SLOTS + 8;
    // Length of the long hold-off on the result side.
    localparam int RX_HOLD_CYCLES  = 300;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 4000;

    // One expected result transaction.
    typedef struct packed {
        logic signed [MIX_W-1:0] sample;
        logic                    saturated;
        logic                    dropped;
        logic [VOICES_W-1:0]     voices;
    } mix_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_write = 1'b0;
    logic [spvm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [LEN_W-1:0]                     cfg_data = '0;
    logic                                 item_valid = 1'b0;
    logic                                 item_ready;
    logic [spvm_pkg::ACTION_W-1:0]        action = spvm_pkg::ACT_NOP;
    logic [spvm_pkg::SOUND_W-1:0]         sound = spvm_pkg::SND_BEEP;
    logic [ADDR_W-1:0]                    table_addr = '0;
    logic signed [SAMPLE_W-1:0]           table_value = '0;
    logic                                 result_valid;
    logic                                 result_ready = 1'b0;
    logic signed [MIX_W-1:0]              mix_sample;
    logic                                 mix_saturated;
    logic                                 trigger_dropped;
    logic [VOICES_W-1:0]                  active_voices;

    // Idling controls: random gaps on the item side, random stalls on the result
    // side, and a request for one long hold-off of the result channel.
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit rx_hold_req = 1'b0;

    int error_count = 0;
    int idle_cycles = 0;
    int items_sent  = 0;

    // Predicted state of the mixer: the wave table with a record of which words have
    // been loaded, the voice slots and the three length registers.
    logic signed [SAMPLE_W-1:0] wave_mem [0:TABLE_WORDS-1];
    bit                         word_loaded [0:TABLE_WORDS-1];
    logic [ADDR_W-1:0]          voice_pos [0:VOICE_SLOTS-1];
    spvm_pkg::spvm_sound_t      voice_snd [0:VOICE_SLOTS-1];
    bit                         voice_busy [0:VOICE_SLOTS-1];
    logic [LEN_W-1:0]           sound_len [0:2];

    // Results predicted for accepted items and not yet seen on the result channel.
    mix_result_t queued_mix_results [$];

    sample_playback_voice_mixer_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .action          (action),
        .sound           (sound),
        .table_addr      (table_addr),
        .table_value     (table_value),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .mix_sample      (mix_sample),
        .mix_saturated   (mix_saturated),
        .trigger_dropped (trigger_dropped),
        .active_voices   (active_voices)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A length register above the table depth behaves as the table depth.
    function automatic int effective_len(spvm_pkg::spvm_sound_t snd);
        int len;
        len = int'(sound_len[int'(snd)]);
        return (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
    endfunction

    // Finds a table word that the next tick would read but that has never been
    // loaded. Such a read is outside the block's contract, so the stimulus loads
    // the word first.
    function automatic bit find_unloaded_word(output int word_idx);
        int len;
        int pos;
        int base;
        word_idx = 0;
        for (int i = 0; i < VOICE_SLOTS; i++)
        begin
            if (voice_busy[i])
            begin
                len  = effective_len(voice_snd[i]);
                pos  = int'(voice_pos[i]);
                base = int'(voice_snd[i]) * TABLE_DEPTH;
                if (pos < len && !word_loaded[base + pos])
                begin
                    word_idx = base + pos;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Advances the predicted mixer by one accepted item and gives its result.
    function automatic mix_result_t mix_one_item(spvm_pkg::spvm_action_t act,
                                                 spvm_pkg::spvm_sound_t snd,
                                                 logic [ADDR_W-1:0] addr,
                                                 logic signed [SAMPLE_W-1:0] val);
        mix_result_t res;
        int sum;
        int len;
        int pos;
        int slot;
        int busy_count;
        res = '0;
        sum = 0;
        case (act)
            spvm_pkg::ACT_TICK:
            begin
                for (int i = 0; i < VOICE_SLOTS; i++)
                begin
                    if (voice_busy[i])
                    begin
                        len = effective_len(voice_snd[i]);
                        pos = int'(voice_pos[i]);
                        // A voice already at or past its length adds nothing.
                        if (pos < len)
                        begin
                            sum += wave_mem[int'(voice_snd[i]) * TABLE_DEPTH + pos];
                            pos++;
                        end
                        if (pos >= len)
                        begin
                            voice_busy[i] = 1'b0;
                            voice_pos[i]  = '0;
                        end
                        else
                        begin
                            voice_pos[i] = pos[ADDR_W-1:0];
                        end
                    end
                end
                if (sum > spvm_pkg::MIX_MAX)
                begin
                    sum = spvm_pkg::MIX_MAX;
                    res.saturated = 1'b1;
                end
                else if (sum < spvm_pkg::MIX_MIN)
                begin
                    sum = spvm_pkg::MIX_MIN;
                    res.saturated = 1'b1;
                end
            end
            spvm_pkg::ACT_TRIGGER:
            begin
                // A trigger of the fourth sound code is ignored without a flag.
                if (snd != spvm_pkg::SND_INVALID)
                begin
                    slot = -1;
                    for (int i = 0; i < VOICE_SLOTS; i++)
                        if (!voice_busy[i] && slot < 0)
                            slot = i;
                    if (slot >= 0)
                    begin
                        voice_busy[slot] = 1'b1;
                        voice_pos[slot]  = '0;
                        voice_snd[slot]  = snd;
                    end
                    else
                    begin
                        res.dropped = 1'b1;
                    end
                end
            end
            spvm_pkg::ACT_LOAD:
            begin
                if (snd != spvm_pkg::SND_INVALID && int'(addr) < TABLE_DEPTH)
                begin
                    wave_mem[int'(snd) * TABLE_DEPTH + int'(addr)]    = val;
                    word_loaded[int'(snd) * TABLE_DEPTH + int'(addr)] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        busy_count = 0;
        for (int i = 0; i < VOICE_SLOTS; i++)
            if (voice_busy[i])
                busy_count++;
        res.sample = sum[MIX_W-1:0];
        res.voices = busy_count[VOICES_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Offers one item and waits for its transaction. The call begins at an edge at
    // which the previous item was accepted, so valid either stays high with the new
    // payload or is lowered for a random gap, never both in the same step.
    task automatic send_item(input spvm_pkg::spvm_action_t act,
                             input spvm_pkg::spvm_sound_t snd,
                             input logic [ADDR_W-1:0] addr,
                             input logic signed [SAMPLE_W-1:0] val);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item_valid  <= 1'b1;
        action      <= act;
        sound       <= snd;
        table_addr  <= addr;
        table_value <= val;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        // The transaction took place at this edge.
        queued_mix_results.push_back(mix_one_item(act, snd, addr, val));
        items_sent++;
    endtask

    // Sends a tick, first loading any word that an active voice is about to read.
    task automatic send_tick();
        int word_idx;
        while (find_unloaded_word(word_idx))
            send_item(spvm_pkg::ACT_LOAD, spvm_pkg::spvm_sound_t'(word_idx / TABLE_DEPTH),
                      ADDR_W'(word_idx % TABLE_DEPTH), SAMPLE_W'($urandom));
        send_item(spvm_pkg::ACT_TICK, spvm_pkg::spvm_sound_t'($urandom_range(0, 3)),
                  ADDR_W'($urandom), SAMPLE_W'($urandom));
    endtask

    function automatic spvm_pkg::spvm_sound_t pick_sound();
        if ($urandom_range(0, 9) == 0)
            return spvm_pkg::SND_INVALID;
        return spvm_pkg::spvm_sound_t'($urandom_range(0, 2));
    endfunction

    // Holds the item side idle until every predicted result has arrived, then lets
    // the block finish whatever it is still doing.
    task automatic drain_results();
        item_valid <= 1'b0;
        while (queued_mix_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; must only be issued while the block is idle.
    task automatic write_length_reg(input spvm_pkg::spvm_reg_t idx,
                                    input logic [LEN_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx != spvm_pkg::REG_UNUSED)
            sound_len[int'(idx)] = data;
        @(posedge clk);
    endtask

    task automatic set_lengths(input logic [LEN_W-1:0] beep_len,
                               input logic [LEN_W-1:0] pew_len,
                               input logic [LEN_W-1:0] boom_len);
        drain_results();
        write_length_reg(spvm_pkg::REG_BEEP_LENGTH, beep_len);
        write_length_reg(spvm_pkg::REG_PEW_LENGTH, pew_len);
        write_length_reg(spvm_pkg::REG_BOOM_LENGTH, boom_len);
    endtask

    // A stream of random items, the count including the loads that ticks bring in;
    // the percentages give the share of triggers, loads and idle actions, and the
    // rest are ticks. Half the loads land near the start of a table, where voices
    // actually read.
    task automatic run_random_mix(input int count, input int trig_pct,
                                  input int load_pct, input int nop_pct);
        int pick;
        int first;
        logic [ADDR_W-1:0] addr;
        first = items_sent;
        while (items_sent - first < count)
        begin
            pick = $urandom_range(0, 99);
            addr = $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 63))
                                        : ADDR_W'($urandom_range(0, TABLE_DEPTH - 1));
            if (pick < trig_pct)
                send_item(spvm_pkg::ACT_TRIGGER, pick_sound(), addr, SAMPLE_W'($urandom));
            else if (pick < trig_pct + load_pct)
                send_item(spvm_pkg::ACT_LOAD, pick_sound(), addr, SAMPLE_W'($urandom));
            else if (pick < trig_pct + load_pct + nop_pct)
                send_item(spvm_pkg::ACT_NOP, spvm_pkg::spvm_sound_t'($urandom_range(0, 3)),
                          addr, SAMPLE_W'($urandom));
            else
                send_tick();
        end
    endtask

    // Hand-picked items: the idle action, ignored sound codes, the widest sample
    // words, voices of zero length, a length cut short under a playing voice and a
    // length beyond the table.
    task automatic test_directed_cases();
        // Nothing plays yet, so the idle action and a tick both give zero.
        send_item(spvm_pkg::ACT_NOP, spvm_pkg::SND_BOOM, 14'h3FFF, 16'sh7FFF);
        send_tick();
        send_item(spvm_pkg::ACT_TRIGGER, spvm_pkg::SND_INVALID, 14'h0000, 16'sh0000);
        send_item(spvm_pkg::ACT_LOAD, spvm_pkg::SND_INVALID, 14'h3FFF, 16'shFFFF);

        set_lengths(15'd3, 15'd1, 15'd0);
        write_length_reg(spvm_pkg::REG_UNUSED, 15'h7FFF);
        send_item(spvm_pkg::ACT_LOAD, spvm_pkg::SND_BEEP, 14'h0000, 16'sh7FFF);
        send_item(spvm_pkg::ACT_LOAD, spvm_pkg::SND_BEEP, 14'h0001, 16'sh8000);
        send_item(spvm_pkg::ACT_LOAD, spvm_pkg::SND_BEEP, 14'h0002, 16'sh0001);
        send_item(spvm_pkg::ACT_LOAD, spvm_pkg::SND_PEW, 14'h0000, 16'sh7FFF);
        send_item(spvm_pkg::ACT_LOAD, spvm_pkg::SND_PEW, 14'h3FFF, 16'sh8000);

        // Two beeps, one pew and a boom of zero length; the boom adds nothing and
        // is freed on the first tick, the pew ends after one word.
        send_item(spvm_pkg::ACT_TRIGGER, spvm_pkg::SND_BEEP, 14'h0000, 16'sh0000);
        send_item(spvm_pkg::ACT_TRIGGER, spvm_pkg::SND_PEW, 14'h0000, 16'sh0000);
        send_item(spvm_pkg::ACT_TRIGGER, spvm_pkg::SND_BOOM, 14'h0000, 16'sh0000);
        send_item(spvm_pkg::ACT_TRIGGER, spvm_pkg::SND_BEEP, 14'h0000, 16'sh0000);
        repeat (3) send_tick();

        // Shorten the beep under a playing voice: it is freed silently.
        send_item(spvm_pkg::ACT_TRIGGER, spvm_pkg::SND_BEEP, 14'h0000, 16'sh0000);
        send_tick();
        set_lengths(15'd1, 15'd1, 15'h7FFF);
        send_tick();

        // The boom length now exceeds the table and acts as the full depth.
        send_item(spvm_pkg::ACT_TRIGGER, spvm_pkg::SND_BOOM, 14'h0000, 16'sh0000);
        repeat (2) send_tick();
    endtask

    // Short sounds: voices come and go quickly, and slots fill at times.
    task automatic test_short_sounds();
        set_lengths(15'($urandom_range(1, 48)), 15'($urandom_range(1, 48)),
                    15'($urandom_range(1, 48)));
        run_random_mix(250, 30, 15, 5);
        set_lengths(15'($urandom_range(1, 20)), 15'd0, 15'($urandom_range(1, 60)));
        run_random_mix(250, 30, 15, 5);
    endtask

    // Lengths at, near and beyond the table depth beside short ones; long voices stay for the whole run.
    task automatic test_long_sounds();
        set_lengths(15'd16384, 15'd16383, 15'd0);
        run_random_mix(300, 12, 15, 5);
        set_lengths(15'h7FFF, 15'd1, 15'd16384);
        run_random_mix(200, 12, 15, 5);
    endtask

    // Dense triggers on long sounds fill every slot, so triggers are dropped; the
    // lengths are then cut short, which frees the long voices.
    task automatic test_voice_exhaustion();
        set_lengths(15'd16384, 15'd5000, 15'd30000);
        run_random_mix(150, 70, 5, 5);
        set_lengths(15'd2, 15'd3, 15'd0);
        run_random_mix(100, 40, 10, 5);
    endtask

    // The result side holds off for a long stretch while items keep coming, so the
    // block fills up and stops taking items; later the sender waits for every result.
    task automatic test_backpressure();
        set_lengths(15'($urandom_range(4, 32)), 15'($urandom_range(4, 32)),
                    15'($urandom_range(4, 32)));
        rx_hold_req = 1'b1;
        run_random_mix(80, 30, 15, 5);
        drain_results();
        run_random_mix(60, 30, 15, 5);
    endtask

    // The last part runs at full rate on both sides.
    task automatic test_no_idling();
        set_lengths(15'($urandom_range(1, 64)), 15'($urandom_range(1, 64)),
                    15'($urandom_range(1, 64)));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random_mix(250, 25, 15, 5);
    endtask

    // Result side: random stall bursts, the long hold-off when requested, and
    // otherwise always ready.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                hold_left   = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Each result transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        mix_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (queued_mix_results.size() == 0)
            begin
                report_mismatch($sformatf("result with no item pending, mix_sample %0d",
                                          mix_sample));
            end
            else
            begin
                want = queued_mix_results.pop_front();
                if (mix_sample !== want.sample)
                    report_mismatch($sformatf("mix_sample %0d, expected %0d",
                                              mix_sample, $signed(want.sample)));
                if (mix_saturated !== want.saturated)
                    report_mismatch($sformatf("mix_saturated %0b, expected %0b",
                                              mix_saturated, want.saturated));
                if (trigger_dropped !== want.dropped)
                    report_mismatch($sformatf("trigger_dropped %0b, expected %0b",
                                              trigger_dropped, want.dropped));
                if (active_voices !== want.voices)
                    report_mismatch($sformatf("active_voices %0d, expected %0d",
                                              active_voices, want.voices));
            end
        end
    end

    // Watchdog: too long without any transaction on either channel means a hang.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        // Predicted state after reset; the wave table starts unloaded.
        for (int i = 0; i < VOICE_SLOTS; i++)
        begin
            voice_busy[i] = 1'b0;
            voice_pos[i]  = '0;
            voice_snd[i]  = spvm_pkg::SND_BEEP;
        end
        for (int i = 0; i < TABLE_WORDS; i++)
        begin
            wave_mem[i]    = '0;
            word_loaded[i] = 1'b0;
        end
        sound_len[0] = spvm_pkg::BEEP_LENGTH_RST;
        sound_len[1] = spvm_pkg::PEW_LENGTH_RST;
        sound_len[2] = spvm_pkg::BOOM_LENGTH_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_short_sounds();
        test_long_sounds();
        test_voice_exhaustion();
        test_backpressure();
        test_no_idling();
        drain_results();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
